/* sv/vfra_pkg.sv */
// Shared types and constants for the variable frame ring allocator.
// Used by vfra_ctrl, vfra_dpath and the top level; depends on nothing.
`default_nettype none

package vfra_pkg;

  // Descriptor queue geometry.
  localparam int MAX_FRAMES = 32;
  localparam int FIFO_AW    = $clog2(MAX_FRAMES);
  localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);

  // Field widths.
  localparam int POS_W  = 16;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 3;

  // Ring size after reset.
  localparam logic [POS_W-1:0] BUFFER_SIZE_RESET = 16'd4096;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_RESERVE = 3'd0,
    REQ_COMMIT  = 3'd1,
    REQ_CANCEL  = 3'd2,
    REQ_PEEK    = 3'd3,
    REQ_POP     = 3'd4,
    REQ_RELEASE = 3'd5,
    REQ_RESET   = 3'd6
  } req_e;

  // Status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_NO_RESERVE = 3'd2,
    ST_QUEUE_FULL = 3'd3,
    ST_EMPTY      = 3'd4,
    ST_NO_HOLD    = 3'd5,
    ST_ZERO_SIZE  = 3'd6
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request beat
    logic execute;  // apply the request and load the result register
  } cmd_t;

endpackage

`default_nettype wire

/* sv/variable_frame_ring_allocator.sv */
// Offset allocator for variable-length frames held back to back in a byte ring, with a
// queue of up to 32 frame descriptors. Each request beat produces exactly one result beat.
// A request is accepted in S_IDLE, waits in S_FETCH for the registered read of the front
// descriptor from the queue memory, and executes in S_EXEC, which loads the result register;
// the next request is accepted in the cycle after execution, so a new request is not taken
// until the one before it has executed.
// A result waiting in the output register does not block acceptance of the next request;
// execution of that request waits until the output register frees up. The ring size
// register resets to 4096 bytes and should only be written while no request is in flight.
// Depends on vfra_pkg, vfra_ctrl and vfra_dpath.
`default_nettype none

module variable_frame_ring_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [vfra_pkg::POS_W-1:0]   cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [vfra_pkg::REQ_W-1:0]   req_type,
  input  wire logic [vfra_pkg::POS_W-1:0]   req_size,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [vfra_pkg::STAT_W-1:0]  status,
  output logic      [vfra_pkg::POS_W-1:0]   frame_offset,
  output logic      [vfra_pkg::POS_W-1:0]   frame_length,
  output logic      [vfra_pkg::COUNT_W-1:0] frames_queued
);
  import vfra_pkg::*;

  cmd_t cmd;

  // Request sequencing.
  vfra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Pointers, descriptor queue and result.
  vfra_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .req_type      (req_type),
    .req_size      (req_size),
    .status        (status),
    .frame_offset  (frame_offset),
    .frame_length  (frame_length),
    .frames_queued (frames_queued)
  );

endmodule

`default_nettype wire

/* sv/vfra_ctrl.sv */
// Controller for the frame ring allocator: sequences fetch and execute of one request.
// Depends on vfra_pkg.
`default_nettype none

module vfra_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output vfra_pkg::cmd_t     cmd
);
  import vfra_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;

  // The result register can take a new beat when empty or being drained.
  assign slot_free = !out_valid || out_ready;

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_FETCH;
      end
      S_FETCH: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_FETCH: begin
      end
      S_EXEC: begin
        cmd.execute = slot_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/vfra_dpath.sv */
// Datapath for the frame ring allocator: ring pointers, reservation, descriptor queue
// memory and result register. Depends on vfra_pkg.
`default_nettype none

module vfra_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire vfra_pkg::cmd_t               cmd,
  input  wire logic                         cfg_wr_en,
  input  wire logic [vfra_pkg::POS_W-1:0]   cfg_wr_data,
  input  wire logic [vfra_pkg::REQ_W-1:0]   req_type,
  input  wire logic [vfra_pkg::POS_W-1:0]   req_size,
  output logic      [vfra_pkg::STAT_W-1:0]  status,
  output logic      [vfra_pkg::POS_W-1:0]   frame_offset,
  output logic      [vfra_pkg::POS_W-1:0]   frame_length,
  output logic      [vfra_pkg::COUNT_W-1:0] frames_queued
);
  import vfra_pkg::*;

  // Configuration and request registers.
  logic [POS_W-1:0]   buffer_size;
  logic [REQ_W-1:0]   req_q;
  logic [POS_W-1:0]   size_q;

  // Allocator state.
  logic [POS_W-1:0]   rear_pos,       rear_pos_next;
  logic [POS_W-1:0]   front_pos,      front_pos_next;
  logic               reserved_valid, reserved_valid_next;
  logic [POS_W-1:0]   reserved_pos,   reserved_pos_next;
  logic [POS_W-1:0]   reserved_len,   reserved_len_next;
  logic               front_held,     front_held_next;
  logic [FIFO_AW-1:0] fifo_head,      fifo_head_next;
  logic [FIFO_AW-1:0] fifo_tail,      fifo_tail_next;
  logic [COUNT_W-1:0] fifo_count,     fifo_count_next;

  // Descriptor memory: offset in the low half, length in the high half.
  logic [2*POS_W-1:0] desc_mem [MAX_FRAMES];
  logic [2*POS_W-1:0] desc_rd;
  logic               desc_we;
  logic [2*POS_W-1:0] desc_wd;

  // Result of the request under execution.
  logic [STAT_W-1:0]  res_status;
  logic [POS_W-1:0]   res_offset;
  logic [POS_W-1:0]   res_length;

  // Helpers for reserve placement.
  logic [POS_W-1:0]   room_end;
  logic [POS_W-1:0]   gap_mid;
  logic [POS_W-1:0]   front_end;

  assign room_end  = (buffer_size > rear_pos) ? buffer_size - rear_pos : '0;
  assign gap_mid   = front_pos - rear_pos;
  assign front_end = desc_rd[POS_W-1:0] + desc_rd[2*POS_W-1:POS_W];

  // Configuration and request capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUFFER_SIZE_RESET;
    end else if (cfg_wr_en) begin
      buffer_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= req_type;
      size_q <= req_size;
    end
  end

  // Descriptor memory: one write port at the tail, registered read at the head.
  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[fifo_tail] <= desc_wd;
    end
    desc_rd <= desc_mem[fifo_head];
  end

  // Request decode and state update.
  always_comb begin
    rear_pos_next       = rear_pos;
    front_pos_next      = front_pos;
    reserved_valid_next = reserved_valid;
    reserved_pos_next   = reserved_pos;
    reserved_len_next   = reserved_len;
    front_held_next     = front_held;
    fifo_head_next      = fifo_head;
    fifo_tail_next      = fifo_tail;
    fifo_count_next     = fifo_count;
    desc_we             = 1'b0;
    desc_wd             = {size_q, reserved_pos};
    res_status          = ST_OK;
    res_offset          = '0;
    res_length          = '0;

    unique case (req_q)
      REQ_RESERVE: begin
        if (size_q == '0) begin
          res_status = ST_ZERO_SIZE;
        end else begin
          reserved_valid_next = 1'b0;
          res_status          = ST_NO_SPACE;
          if (rear_pos > front_pos || (rear_pos == front_pos && fifo_count == '0)) begin
            // Free space runs to the end of the ring, then wraps before the front.
            if (room_end >= size_q) begin
              reserved_valid_next = 1'b1;
              reserved_pos_next   = rear_pos;
              res_offset          = rear_pos;
              res_status          = ST_OK;
            end else if (front_pos >= size_q) begin
              reserved_valid_next = 1'b1;
              reserved_pos_next   = '0;
              res_status          = ST_OK;
            end
          end else if (rear_pos < front_pos) begin
            // Free space is the gap between rear and front.
            if (gap_mid >= size_q) begin
              reserved_valid_next = 1'b1;
              reserved_pos_next   = rear_pos;
              res_offset          = rear_pos;
              res_status          = ST_OK;
            end
          end
          if (res_status == ST_OK) begin
            reserved_len_next = size_q;
          end
        end
      end
      REQ_COMMIT: begin
        if (!reserved_valid) begin
          res_status = ST_NO_RESERVE;
        end else if (size_q == '0) begin
          res_status = ST_ZERO_SIZE;
        end else if (size_q > reserved_len) begin
          res_status = ST_NO_RESERVE;
        end else if (fifo_count >= COUNT_W'(MAX_FRAMES)) begin
          res_status = ST_QUEUE_FULL;
        end else begin
          desc_we             = 1'b1;
          fifo_tail_next      = (fifo_tail == FIFO_AW'(MAX_FRAMES - 1)) ? '0 : fifo_tail + 1'b1;
          fifo_count_next     = fifo_count + 1'b1;
          rear_pos_next       = reserved_pos + size_q;
          res_offset          = reserved_pos;
          reserved_valid_next = 1'b0;
          reserved_pos_next   = '0;
          reserved_len_next   = '0;
        end
      end
      REQ_CANCEL: begin
        if (!reserved_valid) begin
          res_status = ST_NO_RESERVE;
        end else begin
          reserved_valid_next = 1'b0;
          reserved_pos_next   = '0;
          reserved_len_next   = '0;
        end
      end
      REQ_PEEK: begin
        front_held_next = 1'b0;
        if (fifo_count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_offset      = desc_rd[POS_W-1:0];
          res_length      = desc_rd[2*POS_W-1:POS_W];
          front_held_next = 1'b1;
        end
      end
      REQ_POP: begin
        if (!front_held) begin
          res_status = ST_NO_HOLD;
        end else begin
          front_held_next = 1'b0;
          if (fifo_count == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_offset      = desc_rd[POS_W-1:0];
            res_length      = desc_rd[2*POS_W-1:POS_W];
            fifo_head_next  = (fifo_head == FIFO_AW'(MAX_FRAMES - 1)) ? '0 : fifo_head + 1'b1;
            fifo_count_next = fifo_count - 1'b1;
            front_pos_next  = front_end;
          end
        end
      end
      REQ_RELEASE: begin
        if (!front_held) begin
          res_status = ST_NO_HOLD;
        end else begin
          front_held_next = 1'b0;
        end
      end
      REQ_RESET: begin
        rear_pos_next       = '0;
        front_pos_next      = '0;
        reserved_valid_next = 1'b0;
        reserved_pos_next   = '0;
        reserved_len_next   = '0;
        front_held_next     = 1'b0;
        fifo_head_next      = '0;
        fifo_tail_next      = '0;
        fifo_count_next     = '0;
      end
      default: begin
      end
    endcase
  end

  // Allocator state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rear_pos       <= '0;
      front_pos      <= '0;
      reserved_valid <= 1'b0;
      reserved_pos   <= '0;
      reserved_len   <= '0;
      front_held     <= 1'b0;
      fifo_head      <= '0;
      fifo_tail      <= '0;
      fifo_count     <= '0;
    end else if (cmd.execute) begin
      rear_pos       <= rear_pos_next;
      front_pos      <= front_pos_next;
      reserved_valid <= reserved_valid_next;
      reserved_pos   <= reserved_pos_next;
      reserved_len   <= reserved_len_next;
      front_held     <= front_held_next;
      fifo_head      <= fifo_head_next;
      fifo_tail      <= fifo_tail_next;
      fifo_count     <= fifo_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status        <= res_status;
      frame_offset  <= res_offset;
      frame_length  <= res_length;
      frames_queued <= fifo_count_next;
    end
  end

endmodule

`default_nettype wire
